[hdl/lpd_pkg.sv]
// Shared types and constants for the length-prefix deframer.
// No dependencies; imported by every module of the block.
package lpd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 31;
  localparam int unsigned SHIFT_W    = 24;  // header bytes held before the last one arrives
  localparam int unsigned HDR_BYTES  = 4;
  localparam int unsigned HCNT_W     = $clog2(HDR_BYTES);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W     = QPTR_W + 1;

  localparam logic [LEN_W-1:0]  MAX_FRAME_RESET = 31'd65536;
  localparam logic [HCNT_W-1:0] HCNT_LAST       = HCNT_W'(HDR_BYTES - 1);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ABORTED = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ABORT   = 2'd2,
    KIND_DISCARD = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] payload;
    logic              first;
    logic              last;
  } res_t;

endpackage

[hdl/lpd_front.sv]
// Front end of the deframer: accepts bytes, tracks header/payload/abort phase,
// and classifies each byte into at most one result. Depends on lpd_pkg.
module lpd_front import lpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata,
  input  logic              in_xfer,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_start,
  output logic              res_valid,
  output res_t              res
);

  phase_t             phase, phase_next;
  logic [HCNT_W-1:0]  header_count, header_count_next;
  logic [SHIFT_W-1:0] length_shift, length_shift_next;
  logic [LEN_W-1:0]   bytes_left, bytes_left_next;
  logic               first_pending, first_pending_next;
  logic [LEN_W-1:0]   max_frame_size;

  // state as seen after an optional new-connection clear
  phase_t             eff_phase;
  logic [HCNT_W-1:0]  eff_count;
  logic [SHIFT_W-1:0] eff_shift;
  logic [LEN_W-1:0]   eff_left;
  logic               eff_first;
  logic               unfinished;
  logic [31:0]        len;
  logic               header_done;
  logic               len_bad;
  logic               len_zero;
  logic               is_last;

  always_comb begin
    eff_phase   = in_start ? PH_HEADER : phase;
    eff_count   = in_start ? '0 : header_count;
    eff_shift   = in_start ? '0 : length_shift;
    eff_left    = in_start ? '0 : bytes_left;
    eff_first   = in_start ? 1'b0 : first_pending;
    unfinished  = (phase == PH_PAYLOAD) || (phase == PH_HEADER && header_count != '0);
    len         = {eff_shift, in_byte};
    header_done = (eff_count == HCNT_LAST);
    len_bad     = len[31] || (len[LEN_W-1:0] > max_frame_size);
    len_zero    = (len == 32'd0);
    is_last     = (eff_left <= LEN_W'(1));
  end

  // next-state block
  always_comb begin
    phase_next         = eff_phase;
    header_count_next  = eff_count;
    length_shift_next  = eff_shift;
    bytes_left_next    = eff_left;
    first_pending_next = eff_first;
    case (eff_phase)
      PH_HEADER: begin
        if (header_done) begin
          header_count_next = '0;
          length_shift_next = '0;
          if (len_bad) begin
            phase_next         = PH_ABORTED;
            bytes_left_next    = '0;
            first_pending_next = 1'b0;
          end else if (!len_zero) begin
            phase_next         = PH_PAYLOAD;
            bytes_left_next    = len[LEN_W-1:0];
            first_pending_next = 1'b1;
          end
        end else begin
          header_count_next = eff_count + HCNT_W'(1);
          length_shift_next = len[SHIFT_W-1:0];
        end
      end
      PH_PAYLOAD: begin
        first_pending_next = 1'b0;
        if (is_last) begin
          phase_next      = PH_HEADER;
          bytes_left_next = '0;
        end else begin
          bytes_left_next = eff_left - LEN_W'(1);
        end
      end
      default: begin
        // aborted: drop the byte, hold everything
      end
    endcase
  end

  // output block
  always_comb begin
    res_valid   = 1'b0;
    res.kind    = KIND_PAYLOAD;
    res.payload = '0;
    res.first   = 1'b0;
    res.last    = 1'b0;
    if (in_start && unfinished) begin
      res_valid = 1'b1;
      res.kind  = KIND_DISCARD;
    end
    case (eff_phase)
      PH_HEADER: begin
        if (header_done) begin
          if (len_bad) begin
            res_valid = 1'b1;
            res.kind  = KIND_ABORT;
          end else if (len_zero) begin
            res_valid = 1'b1;
            res.kind  = KIND_EMPTY;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid   = 1'b1;
        res.kind    = KIND_PAYLOAD;
        res.payload = in_byte;
        res.first   = eff_first;
        res.last    = is_last;
      end
      default: begin
      end
    endcase
    res_valid = res_valid && in_xfer;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= '0;
      length_shift   <= '0;
      bytes_left     <= '0;
      first_pending  <= 1'b0;
      max_frame_size <= MAX_FRAME_RESET;
    end else begin
      if (cfg_we) begin
        max_frame_size <= cfg_wdata;
      end
      if (in_xfer) begin
        phase         <= phase_next;
        header_count  <= header_count_next;
        length_shift  <= length_shift_next;
        bytes_left    <= bytes_left_next;
        first_pending <= first_pending_next;
      end
    end
  end

endmodule

[hdl/lpd_queue.sv]
// Short result queue between the front and back ends of the deframer.
// Register-based FIFO of QUEUE_DEPTH entries; depends on lpd_pkg.
module lpd_queue import lpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  input  logic pop,
  output res_t pop_data,
  output logic empty,
  output logic full
);

  res_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign empty    = (count == '0);
  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/lpd_back.sv]
// Back end of the deframer: pulls results from the queue into the output
// register and presents them on the master stream. Depends on lpd_pkg.
module lpd_back import lpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  res_t              q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_data,
  output logic [2:0]        out_user,
  output logic              out_last
);

  res_t out_reg;
  logic valid;

  // refill whenever the register is empty or being drained this cycle
  assign q_pop = !q_empty && (!valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (q_pop) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_reg <= q_data;
    end
  end

  assign out_valid = valid;
  assign out_data  = out_reg.payload;
  assign out_user  = {out_reg.first, out_reg.kind};
  assign out_last  = out_reg.last;

endmodule

[hdl/length_prefix_deframer.sv]
// Top level of the length-prefix deframer: front parser, result queue, and
// output stage. Depends on lpd_pkg, lpd_front, lpd_queue and lpd_back.
//
//  channel  | direction | tdata            | tuser                       | tlast
//  ---------+-----------+------------------+-----------------------------+--------------
//  s_axis   | in        | [7:0] rx_byte    | [0] connection_start        | -
//  m_axis   | out       | [7:0] payload    | [1:0] kind, [2] first       | last_of_frame
//  cfg      | in        | cfg_wdata[30:0] max_frame_size, written when cfg_we is high
//
// One byte is taken per cycle while s_axis_tready is high; each result passes
// through the front logic, the queue and the output register on its way out.
// A four-entry queue decouples parsing from the output; s_axis_tready drops
// only when that queue is full, i.e. after the output has been stalled.
// Reset (rst, synchronous) returns the parser to the header phase, empties the
// queue and restores max_frame_size to 65536.
module length_prefix_deframer import lpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata,      // [30:0] max_frame_size
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic              s_axis_tuser,   // [0] connection_start
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] payload_byte
  output logic [2:0]        m_axis_tuser,   // [1:0] kind, [2] first_of_frame
  output logic              m_axis_tlast    // last_of_frame
);

  logic in_xfer;
  logic res_valid;
  res_t res;
  logic q_full;
  logic q_empty;
  logic q_pop;
  res_t q_data;

  // take a byte whenever the queue has room for its possible result
  assign s_axis_tready = !q_full;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  lpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_xfer   (in_xfer),
    .in_byte   (s_axis_tdata),
    .in_start  (s_axis_tuser),
    .res_valid (res_valid),
    .res       (res)
  );

  lpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  lpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

[hdl/lpd_chk.sv]
// Port-level checker for the length-prefix deframer, bound to the top level.
// Depends on lpd_pkg.
module lpd_chk import lpd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [BYTE_W-1:0] m_axis_tdata,
  input logic [2:0]        m_axis_tuser,
  input logic              m_axis_tlast
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // non-payload results carry no byte and no frame marks
  a_ctrl_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[1:0] != KIND_PAYLOAD) |->
      (m_axis_tdata == '0) && !m_axis_tuser[2] && !m_axis_tlast)
    else $error("control result with payload fields set");

  // the output is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result presented after reset");

  // input backpressure appears only after the output was stalled
  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output stall");

endmodule

bind length_prefix_deframer lpd_chk u_lpd_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[verif/lpd_checker.sv]
// Result checker for the length-prefix deframer: tracks the input and result
// transfers, predicts each result and compares it field by field.
// Depends on lpd_pkg.
module lpd_checker import lpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [BYTE_W-1:0] s_axis_tdata,
  input  logic              s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [BYTE_W-1:0] m_axis_tdata,
  input  logic [2:0]        m_axis_tuser,
  input  logic              m_axis_tlast,
  output int unsigned       fail_count,
  output int unsigned       results_due
);

  phase_t           ph;
  logic [2:0]       hdr_cnt;
  logic [31:0]      len_acc;
  logic [LEN_W-1:0] remaining;
  logic             first_due;
  logic [LEN_W-1:0] max_len;
  res_t             due_q[$];
  int unsigned      errors = 0;

  task automatic clear_frame();
    ph        = PH_HEADER;
    hdr_cnt   = '0;
    len_acc   = '0;
    remaining = '0;
    first_due = 1'b0;
  endtask

  // Advance the parser by one received byte; queue the result it causes.
  task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic start);
    res_t r;
    bit   hit;
    r   = '0;
    hit = 1'b0;
    if (start) begin
      if (ph == PH_PAYLOAD || (ph == PH_HEADER && hdr_cnt != 0)) begin
        r.kind = KIND_DISCARD;
        hit    = 1'b1;
      end
      clear_frame();
    end
    if (ph == PH_HEADER) begin
      len_acc = {len_acc[23:0], b};
      hdr_cnt = hdr_cnt + 3'd1;
      if (hdr_cnt == 3'd4) begin
        hdr_cnt = '0;
        if (len_acc[31] || len_acc[30:0] > max_len) begin
          ph        = PH_ABORTED;
          remaining = '0;
          first_due = 1'b0;
          r         = '0;
          r.kind    = KIND_ABORT;
          hit       = 1'b1;
        end else if (len_acc == 0) begin
          r.kind = KIND_EMPTY;
          hit    = 1'b1;
        end else begin
          ph        = PH_PAYLOAD;
          remaining = len_acc[30:0];
          first_due = 1'b1;
        end
        len_acc = '0;
      end
    end else if (ph == PH_PAYLOAD) begin
      r.kind    = KIND_PAYLOAD;
      r.payload = b;
      r.first   = first_due;
      r.last    = (remaining <= 1);
      hit       = 1'b1;
      first_due = 1'b0;
      if (r.last) clear_frame();
      else remaining = remaining - 1'b1;
    end
    if (hit) due_q.insert(due_q.size(), r);
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (due_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected result: kind %0d byte %02h first %b last %b",
                 $time, got.kind, got.payload, got.first, got.last);
    end else begin
      want = due_q.pop_front();
      if (want.kind !== got.kind || want.payload !== got.payload ||
          want.first !== got.first || want.last !== got.last) begin
        errors++;
        if (errors <= 10)
          $display({"%0t: mismatch: expected kind %0d byte %02h first %b last %b,",
                    " got kind %0d byte %02h first %b last %b"},
                   $time, want.kind, want.payload, want.first, want.last,
                   got.kind, got.payload, got.first, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      max_len = MAX_FRAME_RESET;
      due_q.delete();
    end else begin
      if (cfg_we) max_len = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready)
        check_result('{kind_t'(m_axis_tuser[1:0]), m_axis_tdata, m_axis_tuser[2],
                       m_axis_tlast});
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tuser);
    end
    fail_count  <= errors;
    results_due <= due_q.size();
  end

endmodule

[verif/tb.sv]
// Top of the length-prefix deframer testbench: clock, reset, byte stimulus,
// random output stalls, watchdog and verdict. Depends on lpd_pkg, lpd_checker
// and length_prefix_deframer.
module tb;
  import lpd_pkg::*;

  localparam int unsigned PHASE_ITEMS = 150;   // input bytes per register setting
  localparam int unsigned SETTLE      = 6;     // cycles for the pipeline to empty
  localparam int unsigned WATCHDOG    = 2000;  // quiet cycles before giving up

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [LEN_W-1:0]  cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [BYTE_W-1:0] s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [BYTE_W-1:0] m_axis_tdata;
  logic [2:0]        m_axis_tuser;
  logic              m_axis_tlast;

  int unsigned       fail_count;
  int unsigned       results_due;
  int unsigned       quiet = 0;
  bit                steady = 1'b0;   // when set, neither side idles
  logic [LEN_W-1:0]  cur_max = MAX_FRAME_RESET;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  length_prefix_deframer uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  lpd_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .results_due   (results_due)
  );

  // Idle length shared by both sides: mostly from the short range, now and then long.
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Result side: bursts of ready broken by stalls; hold ready high while steady.
  initial begin
    int unsigned burst;
    forever begin
      burst = $urandom_range(1, steady ? 200 : 24);
      m_axis_tready <= 1'b1;
      repeat (burst) @(posedge clk);
      if (!steady) begin
        m_axis_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  // Watchdog: any transfer or register write counts as progress.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == WATCHDOG) begin
        $display("[length_prefix_deframer] ERROR");
        $finish;
      end
    end
  end

  // Offer one byte, possibly after an idle gap, and hold it until the transfer.
  // Return at the transfer edge with tvalid still high, so a back-to-back byte
  // only rewrites the data.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
    int unsigned gap;
    gap = (!steady && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Send the first count bytes of a big-endian length header; mark the first
  // one as a connection start if asked.
  task automatic send_len(input logic [31:0] len, input logic start,
                          input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) send_byte(len[31 - 8*i -: 8], start && i == 0);
  endtask

  // Stop sending and wait until every predicted result has come out, then let
  // the pipeline settle: header bytes leave no result to wait for.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_max(input logic [LEN_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    cur_max    = value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random traffic under the current limit, mostly well-formed frames.
  task automatic random_phase();
    int unsigned items;
    int unsigned pick;
    int unsigned n;
    int unsigned lim;
    logic [31:0] len;
    logic        start;
    bit          need_start;
    items      = 0;
    need_start = 1'b1;
    while (items < PHASE_ITEMS) begin
      if ($urandom_range(0, 15) == 0) steady <= !steady;
      pick       = $urandom_range(0, 99);
      start      = need_start || $urandom_range(0, 3) == 0;
      need_start = 1'b0;
      if (pick < 60) begin
        // Well-formed frame; hit the limit exactly now and then.
        lim = (cur_max < 24) ? cur_max : 24;
        if (cur_max <= 64 && $urandom_range(0, 7) == 0) len = cur_max;
        else len = $urandom_range(0, lim);
        send_len(len, start, 4);
        repeat (len) send_byte($urandom_range(0, 255), 1'b0);
        items += 4 + len;
      end else if (pick < 72) begin
        // Corrupt length: top bit set, or anywhere above the limit.
        if (cur_max == {LEN_W{1'b1}} || $urandom_range(0, 1) == 0)
          len = {1'b1, 31'($urandom)};
        else
          len = $urandom_range(32'(cur_max) + 1, 32'h7FFF_FFFF);
        send_len(len, start, 4);
        // Drop whatever follows until the next connection start.
        repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 255), 1'b0);
        items     += 4;
        need_start = 1'b1;
      end else if (pick < 88) begin
        // Cut a frame short; the next connection start must discard it.
        if (cur_max >= 2 && $urandom_range(0, 1) == 0) begin
          len = $urandom_range(2, cur_max);
          send_len(len, start, 4);
          n = $urandom_range(1, (len - 1 < 8) ? len - 1 : 8);
          repeat (n) send_byte($urandom_range(0, 255), 1'b0);
          items += 4 + n;
        end else begin
          n = $urandom_range(1, 3);
          send_len($urandom, start, n);
          items += n;
        end
        need_start = 1'b1;
      end else if (pick < 92) begin
        drain();
      end else begin
        // Stray byte; resync with a connection start afterwards.
        send_byte($urandom_range(0, 255), $urandom_range(0, 1));
        items     += 1;
        need_start = 1'b1;
      end
    end
  endtask

  initial begin
    logic [LEN_W-1:0] limits[7];
    int unsigned      p;
    limits = '{MAX_FRAME_RESET, '0, 31'd1, {LEN_W{1'b1}}, 31'd12, 31'($urandom), 31'd300};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty frame opened by a connection start between frames.
    send_len(32'd0, 1'b1, 4);
    // Two-byte frame carrying the byte extremes, first and last marks.
    send_len(32'd2, 1'b0, 4);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // Half a header, then a new connection: discard, then a three-byte frame cut short.
    send_len(32'd3, 1'b0, 2);
    send_len(32'd3, 1'b1, 4);
    send_byte(8'h11, 1'b0);
    // New connection mid-payload: discard; its header has the top bit set.
    send_len(32'h8000_0000, 1'b1, 4);
    // Aborted connection drops this byte.
    send_byte(8'hFF, 1'b0);
    // New connection after an abort gives no discard; length above the limit.
    send_len(32'h0001_0001, 1'b1, 4);
    drain();

    // Random traffic under a sequence of limits, extremes included.
    for (p = 0; p < 7; p++) begin
      if (p != 0) write_max(limits[p]);
      random_phase();
    end

    drain();
    if (fail_count == 0) $display("[length_prefix_deframer] OK");
    else $display("[length_prefix_deframer] ERROR");
    $finish;
  end

endmodule

[files.f]
hdl/lpd_pkg.sv
hdl/lpd_front.sv
hdl/lpd_queue.sv
hdl/lpd_back.sv
hdl/length_prefix_deframer.sv
hdl/lpd_chk.sv
verif/lpd_checker.sv
verif/tb.sv
